/* hdl/mqtm_pkg.sv */
// shared types and constants for the multi-queue ticket manager
// no dependencies; imported by every module of the block
package mqtm_pkg;

    localparam int NUM_QUEUES_DEF  = 64;
    localparam int QUEUE_DEPTH_DEF = 256;
    localparam int SCAN_CHUNK      = 8;
    localparam int TICKET_W        = 31;

    localparam logic [15:0] SLOT_OFFSET  = 16'h1221;
    localparam logic [15:0] NONCE_OFFSET = 16'h0502;
    localparam logic [15:0] NONCE_MAX    = 16'hffff;

    typedef enum logic [1:0] {
        CMD_CREATE  = 2'd0,
        CMD_DELETE  = 2'd1,
        CMD_ENQUEUE = 2'd2,
        CMD_DEQUEUE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD       = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_NOFREE    = 3'd3,
        ST_FULL      = 3'd4,
        ST_EMPTY     = 3'd5
    } status_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [31:0]        ticket;
        logic signed [31:0] value;
    } in_req_t;

    typedef struct packed {
        status_t                status;
        logic [TICKET_W-1:0]    new_ticket;
        logic signed [31:0]     out_value;
    } result_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } mem_ctl_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_DECODE,
        SQ_SCAN,
        SQ_CREATE,
        SQ_META,
        SQ_ENQ,
        SQ_DEQ_WAIT,
        SQ_FIN
    } seq_state_t;

endpackage

/* hdl/mqtm_ram.sv */
// single-port ram with registered read data
// depends on mqtm_pkg for the access control struct
module mqtm_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 32
) (
    input  logic              aclk,
    input  mqtm_pkg::mem_ctl_t ctl,
    input  logic [AW-1:0]     addr,
    input  logic [DW-1:0]     wdata,
    output logic [DW-1:0]     rdata
);
    import mqtm_pkg::*;

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr) begin
            mem[addr] <= wdata;
        end
        if (ctl.rd) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/mqtm_seq.sv */
// command sequencer: ticket check, free slot scan, nonce counter, queue updates
// depends on mqtm_pkg; drives the slot table and element rams
module mqtm_seq #(
    parameter int NUM_QUEUES  = mqtm_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = mqtm_pkg::QUEUE_DEPTH_DEF,
    parameter int SW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
    parameter int HW = $clog2(QUEUE_DEPTH),
    parameter int CW = $clog2(QUEUE_DEPTH + 1),
    parameter int MW = mqtm_pkg::TICKET_W + HW + CW,
    parameter int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                req_valid,
    output logic                req_ready,
    input  mqtm_pkg::in_req_t   req,
    output logic                res_valid,
    input  logic                res_take,
    output mqtm_pkg::result_t   res,
    output mqtm_pkg::mem_ctl_t  meta_ctl,
    output logic [SW-1:0]       meta_addr,
    output logic [MW-1:0]       meta_wdata,
    input  logic [MW-1:0]       meta_rdata,
    output mqtm_pkg::mem_ctl_t  elem_ctl,
    output logic [AW-1:0]       elem_addr,
    output logic [31:0]         elem_wdata,
    input  logic [31:0]         elem_rdata
);
    import mqtm_pkg::*;

    localparam int NCH  = (NUM_QUEUES + SCAN_CHUNK - 1) / SCAN_CHUNK;
    localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PADW = NCH * SCAN_CHUNK;

    seq_state_t            state_reg, state_next;
    in_req_t               req_reg, req_next;
    logic [SW-1:0]         slot_reg, slot_next;
    logic [CHW-1:0]        chunk_reg, chunk_next;
    logic [AW-1:0]         base_reg, base_next;
    logic [HW-1:0]         pos_reg, pos_next;
    logic [NUM_QUEUES-1:0] in_use_reg, in_use_next;
    logic [15:0]           nonce_reg, nonce_next;
    result_t               res_reg, res_next;

    logic [PADW-1:0]       in_use_pad;
    logic [SCAN_CHUNK-1:0] chunk_bits;
    logic [2:0]            free_pos;
    logic                  free_found;
    logic [15:0]           lk_slot16;
    logic [SW-1:0]         lk_slot;
    logic                  lk_ok;
    logic [TICKET_W-1:0]   rd_ticket;
    logic [HW-1:0]         rd_head;
    logic [CW-1:0]         rd_count;
    logic                  tk_ok;
    logic [HW:0]           tail_sum;
    logic [HW:0]           head_inc;
    logic [HW-1:0]         head_wrap;
    logic [16:0]           nonce_sum;
    logic [15:0]           slot_hi;
    logic [TICKET_W-1:0]   create_ticket;

    // slots past the end read as taken
    always_comb begin
        in_use_pad = '1;
        in_use_pad[NUM_QUEUES-1:0] = in_use_reg;
    end

    assign chunk_bits = in_use_pad[chunk_reg*SCAN_CHUNK +: SCAN_CHUNK];

    always_comb begin
        free_pos   = '0;
        free_found = 1'b0;
        for (int i = SCAN_CHUNK - 1; i >= 0; i--) begin
            if (!chunk_bits[i]) begin
                free_pos   = 3'(i);
                free_found = 1'b1;
            end
        end
    end

    assign lk_slot16 = req_reg.ticket[31:16] - SLOT_OFFSET;
    assign lk_slot   = lk_slot16[SW-1:0];
    assign lk_ok     = (lk_slot16 < 16'(NUM_QUEUES)) && in_use_reg[lk_slot];

    assign rd_ticket = meta_rdata[MW-1 -: TICKET_W];
    assign rd_head   = meta_rdata[CW +: HW];
    assign rd_count  = meta_rdata[CW-1:0];
    assign tk_ok     = ({1'b0, rd_ticket} == req_reg.ticket);

    assign tail_sum  = (HW+1)'(rd_head) + (HW+1)'(rd_count);
    assign head_inc  = (HW+1)'(rd_head) + (HW+1)'(1);
    assign head_wrap = (head_inc == (HW+1)'(QUEUE_DEPTH)) ? '0 : head_inc[HW-1:0];

    assign nonce_sum     = {1'b0, nonce_reg} + {1'b0, NONCE_OFFSET};
    assign slot_hi       = 16'(slot_reg) + SLOT_OFFSET;
    assign create_ticket = {slot_hi[14:0], nonce_sum[15:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= SQ_IDLE;
            in_use_reg <= '0;
            nonce_reg  <= 16'd1;
        end else begin
            state_reg  <= state_next;
            in_use_reg <= in_use_next;
            nonce_reg  <= nonce_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        slot_reg  <= slot_next;
        chunk_reg <= chunk_next;
        base_reg  <= base_next;
        pos_reg   <= pos_next;
        res_reg   <= res_next;
    end

    always_comb begin
        state_next  = state_reg;
        req_next    = req_reg;
        slot_next   = slot_reg;
        chunk_next  = chunk_reg;
        base_next   = base_reg;
        pos_next    = pos_reg;
        in_use_next = in_use_reg;
        nonce_next  = nonce_reg;
        res_next    = res_reg;
        req_ready   = 1'b0;
        res_valid   = 1'b0;
        meta_ctl    = '0;
        meta_addr   = slot_reg;
        meta_wdata  = {rd_ticket, rd_head, rd_count};
        elem_ctl    = '0;
        elem_addr   = base_reg + AW'(pos_reg);
        elem_wdata  = req_reg.value;

        case (state_reg)
            SQ_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    req_next   = req;
                    chunk_next = '0;
                    res_next   = '{status: ST_OK, new_ticket: '0, out_value: '0};
                    state_next = SQ_DECODE;
                end
            end
            SQ_DECODE: begin
                if (req_reg.cmd == CMD_CREATE) begin
                    state_next = SQ_SCAN;
                end else if (!lk_ok) begin
                    res_next.status = ST_BAD;
                    state_next      = SQ_FIN;
                end else begin
                    meta_ctl.rd = 1'b1;
                    meta_addr   = lk_slot;
                    slot_next   = lk_slot;
                    base_next   = AW'(lk_slot) * AW'(QUEUE_DEPTH);
                    state_next  = SQ_META;
                end
            end
            SQ_SCAN: begin
                if (free_found) begin
                    slot_next  = SW'({chunk_reg, free_pos});
                    state_next = SQ_CREATE;
                end else if (chunk_reg == CHW'(NCH - 1)) begin
                    res_next.status = ST_NOFREE;
                    state_next      = SQ_FIN;
                end else begin
                    chunk_next = chunk_reg + CHW'(1);
                end
            end
            SQ_CREATE: begin
                if (nonce_reg != NONCE_MAX) begin
                    nonce_next = nonce_reg + 16'd1;
                end
                if (nonce_sum[16]) begin
                    res_next.status = ST_EXHAUSTED;
                end else begin
                    meta_ctl.wr           = 1'b1;
                    meta_wdata            = {create_ticket, {HW{1'b0}}, {CW{1'b0}}};
                    in_use_next[slot_reg] = 1'b1;
                    res_next.new_ticket   = create_ticket;
                end
                state_next = SQ_FIN;
            end
            SQ_META: begin
                state_next = SQ_FIN;
                if (!tk_ok) begin
                    res_next.status = ST_BAD;
                end else begin
                    case (req_reg.cmd)
                        CMD_DELETE: begin
                            in_use_next[slot_reg] = 1'b0;
                        end
                        CMD_ENQUEUE: begin
                            if (rd_count == CW'(QUEUE_DEPTH)) begin
                                res_next.status = ST_FULL;
                            end else begin
                                pos_next = (tail_sum >= (HW+1)'(QUEUE_DEPTH))
                                         ? HW'(tail_sum - (HW+1)'(QUEUE_DEPTH))
                                         : tail_sum[HW-1:0];
                                meta_ctl.wr = 1'b1;
                                meta_wdata  = {rd_ticket, rd_head, rd_count + CW'(1)};
                                state_next  = SQ_ENQ;
                            end
                        end
                        CMD_DEQUEUE: begin
                            if (rd_count == '0) begin
                                res_next.status = ST_EMPTY;
                            end else begin
                                elem_ctl.rd = 1'b1;
                                elem_addr   = base_reg + AW'(rd_head);
                                meta_ctl.wr = 1'b1;
                                meta_wdata  = {rd_ticket, head_wrap, rd_count - CW'(1)};
                                state_next  = SQ_DEQ_WAIT;
                            end
                        end
                        default: begin
                            res_next.status = ST_BAD;
                        end
                    endcase
                end
            end
            SQ_ENQ: begin
                elem_ctl.wr = 1'b1;
                state_next  = SQ_FIN;
            end
            SQ_DEQ_WAIT: begin
                res_next.out_value = elem_rdata;
                state_next         = SQ_FIN;
            end
            SQ_FIN: begin
                res_valid = 1'b1;
                if (res_take) begin
                    state_next = SQ_IDLE;
                end
            end
            default: begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

/* hdl/multi_queue_ticket_manager.sv */
// top level of the multi-queue ticket manager
// depends on mqtm_pkg, mqtm_ram and mqtm_seq
//
// usage:
//   s_ channel carries one request (cmd, ticket, value); m_ channel returns one
//   result (status, new_ticket, out_value) per request, in request order.
//   s_ready is high while the sequencer is idle; requests are handled one at
//   a time. a request first passes the slot check, where a bad ticket is
//   answered. otherwise the slot table entry is read and its ticket compared;
//   a mismatch, delete, full enqueue or empty dequeue answers there, an
//   enqueue then writes its element, and a dequeue waits for the element
//   ram read. a create scans 8-slot groups from slot 0 up to the lowest free
//   slot, then writes the new ticket unless the nonces are exhausted, or
//   answers no free slot after the last group. every result then waits for
//   the output register; the sequencer goes idle as its result moves there.
//   these steps follow the registered reads of the slot table and element
//   rams and the 8-slot-per-cycle free slot scan.
//   results sit in an output register; the next request is taken while a
//   result waits, and a finished result waits in the sequencer until the
//   output register frees up, so a stalled m_ready holds everything back.
//   reset clears every in-use flag, sets the nonce counter to one and drops
//   m_valid; the rams need no clearing since every read follows a write.
module multi_queue_ticket_manager #(
    parameter int NUM_QUEUES  = mqtm_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = mqtm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mqtm_pkg::in_req_t s_req,
    output logic              m_valid,
    input  logic              m_ready,
    output mqtm_pkg::result_t m_result
);
    import mqtm_pkg::*;

    // slot index, head, count and element address widths
    localparam int SW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int HW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int MW = TICKET_W + HW + CW;
    localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);

    mem_ctl_t      meta_ctl, elem_ctl;
    logic [SW-1:0] meta_addr;
    logic [MW-1:0] meta_wdata, meta_rdata;
    logic [AW-1:0] elem_addr;
    logic [31:0]   elem_wdata, elem_rdata;

    logic    res_valid;
    logic    res_take;
    result_t res;

    logic    m_valid_reg, m_valid_next;
    result_t m_result_reg, m_result_next;

    // per-queue ticket, head and count
    mqtm_ram #(
        .DEPTH (NUM_QUEUES),
        .AW    (SW),
        .DW    (MW)
    ) u_slot_ram (
        .aclk  (aclk),
        .ctl   (meta_ctl),
        .addr  (meta_addr),
        .wdata (meta_wdata),
        .rdata (meta_rdata)
    );

    // queue elements, one region of QUEUE_DEPTH words per slot
    mqtm_ram #(
        .DEPTH (NUM_QUEUES * QUEUE_DEPTH),
        .AW    (AW),
        .DW    (32)
    ) u_elem_ram (
        .aclk  (aclk),
        .ctl   (elem_ctl),
        .addr  (elem_addr),
        .wdata (elem_wdata),
        .rdata (elem_rdata)
    );

    mqtm_seq #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .SW          (SW),
        .HW          (HW),
        .CW          (CW),
        .MW          (MW),
        .AW          (AW)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (s_valid),
        .req_ready  (s_ready),
        .req        (s_req),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res),
        .meta_ctl   (meta_ctl),
        .meta_addr  (meta_addr),
        .meta_wdata (meta_wdata),
        .meta_rdata (meta_rdata),
        .elem_ctl   (elem_ctl),
        .elem_addr  (elem_addr),
        .elem_wdata (elem_wdata),
        .elem_rdata (elem_rdata)
    );

    // output register: loads when empty or being drained this cycle
    assign res_take = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_result_next = m_result_reg;
        if (res_valid && res_take) begin
            m_valid_next  = 1'b1;
            m_result_next = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_result_reg <= m_result_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

endmodule

/* tb/mqtm_result_check.sv */
// result checker for the multi-queue ticket manager: predicts each result
// from the accepted requests and compares it field by field with the block
// depends on mqtm_pkg
module mqtm_result_check #(
    parameter int NUM_QUEUES  = mqtm_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = mqtm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  mqtm_pkg::in_req_t s_req,
    input  logic              m_valid,
    input  logic              m_ready,
    input  mqtm_pkg::result_t m_result,
    output int                mismatches,
    output int                awaited
);
    import mqtm_pkg::*;

    logic                slot_live [NUM_QUEUES];
    logic [TICKET_W-1:0] slot_tkt  [NUM_QUEUES];
    int unsigned         slot_head [NUM_QUEUES];
    int unsigned         slot_fill [NUM_QUEUES];
    logic [31:0]         queue_mem [NUM_QUEUES][QUEUE_DEPTH];
    logic [15:0]         nonce;
    result_t             expected_results [$];
    int                  mismatch_count = 0;
    int                  awaited_count  = 0;

    assign mismatches = mismatch_count;
    assign awaited    = awaited_count;

    // slot a ticket names, or NUM_QUEUES when the ticket does not hold
    function automatic int unsigned find_slot(logic [31:0] tkt);
        int unsigned slot;
        slot = 32'(tkt[31:16]) - 32'(SLOT_OFFSET);
        if (slot >= NUM_QUEUES) begin
            return NUM_QUEUES;
        end
        if (!slot_live[slot]) begin
            return NUM_QUEUES;
        end
        if ({1'b0, slot_tkt[slot]} != tkt) begin
            return NUM_QUEUES;
        end
        return slot;
    endfunction

    // applies one request to the queue state and returns its result
    function automatic result_t apply_request(in_req_t req);
        result_t     res;
        int unsigned slot;
        int unsigned lo;
        int unsigned hi;
        int unsigned pos;
        res = '0;
        res.status = ST_OK;
        if (req.cmd == CMD_CREATE) begin
            slot = NUM_QUEUES;
            for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
                if (!slot_live[i]) begin
                    slot = i;
                end
            end
            if (slot == NUM_QUEUES) begin
                res.status = ST_NOFREE;
            end else begin
                hi = (slot + 32'(SLOT_OFFSET)) & 32'h7fff;
                lo = 32'(nonce) + 32'(NONCE_OFFSET);
                if (nonce != NONCE_MAX) begin
                    nonce = nonce + 16'd1;
                end
                if (lo > 32'hffff || hi != slot + 32'(SLOT_OFFSET)) begin
                    res.status = ST_EXHAUSTED;
                end else begin
                    res.new_ticket  = {hi[14:0], lo[15:0]};
                    slot_live[slot] = 1'b1;
                    slot_tkt[slot]  = res.new_ticket;
                    slot_head[slot] = 0;
                    slot_fill[slot] = 0;
                end
            end
        end else begin
            slot = find_slot(req.ticket);
            if (slot == NUM_QUEUES) begin
                res.status = ST_BAD;
            end else if (req.cmd == CMD_DELETE) begin
                slot_live[slot] = 1'b0;
            end else if (req.cmd == CMD_ENQUEUE) begin
                if (slot_fill[slot] >= QUEUE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    pos = (slot_head[slot] + slot_fill[slot]) % QUEUE_DEPTH;
                    queue_mem[slot][pos] = req.value;
                    slot_fill[slot]++;
                end
            end else begin
                if (slot_fill[slot] == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.out_value = queue_mem[slot][slot_head[slot]];
                    slot_fill[slot]--;
                    slot_head[slot] = (slot_head[slot] + 1) % QUEUE_DEPTH;
                end
            end
        end
        return res;
    endfunction

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                slot_live[i] = 1'b0;
            end
            nonce = 16'd1;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time,
                             m_result);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.status), 32'(m_result.status));
                    check_field("new_ticket", 32'(want.new_ticket),
                                32'(m_result.new_ticket));
                    check_field("out_value", want.out_value, m_result.out_value);
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(apply_request(s_req));
            end
        end
        awaited_count = expected_results.size();
    end

endmodule

/* tb/tb_multi_queue_ticket_manager.sv */
// testbench top for the multi-queue ticket manager: drives requests, stalls
// the result side, and reports the verdict of mqtm_result_check
// depends on mqtm_pkg, multi_queue_ticket_manager and mqtm_result_check
module tb_multi_queue_ticket_manager;
    import mqtm_pkg::*;

    localparam int NQ             = NUM_QUEUES_DEF;
    localparam int DEPTH          = QUEUE_DEPTH_DEF;
    localparam int ITEM_TARGET    = 1950;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;

    logic    aclk    = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    in_req_t s_req   = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    result_t m_result;

    int mismatches;
    int awaited;

    // stimulus bookkeeping: tickets handed out and not yet deleted, and old ones
    logic [31:0] live_tickets  [$];
    logic [31:0] stale_tickets [$];
    int          n_sent        = 0;
    int          n_done        = 0;

    // flags shared between stimulus and the result side, the hold-off counter, and the watchdog's idle count
    bit calm         = 1'b0;
    bit hold_trigger = 1'b0;
    int hold_left    = 0;
    int idle_cycles  = 0;

    always #10 aclk = ~aclk;

    multi_queue_ticket_manager #(
        .NUM_QUEUES (NQ),
        .QUEUE_DEPTH(DEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_result(m_result)
    );

    mqtm_result_check #(
        .NUM_QUEUES (NQ),
        .QUEUE_DEPTH(DEPTH)
    ) result_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result),
        .mismatches(mismatches),
        .awaited   (awaited)
    );

    // result side: random stalls, a calm mode with none, and one long hold-off
    // that the stimulus asks for so the block backs up into its input
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_trigger) begin
            hold_trigger = 1'b0;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 15);
        end
    end

    // learn tickets from successful creates so later requests can name them
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_done++;
            if (m_result.status == ST_OK && m_result.new_ticket != '0) begin
                live_tickets.push_back({1'b0, m_result.new_ticket});
            end
        end
    end

    // watchdog: too long without any handshake on either side ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // offer one request, with a random gap first unless calm, and hold it
    // until the block takes it
    task automatic send_req(input cmd_t op, input logic [31:0] tkt,
                            input logic [31:0] val);
        while (!calm && $urandom_range(99) < 15) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= in_req_t'{op, tkt, val};
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        n_sent++;
    endtask

    // sender pause until every request has its result back
    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (n_done != n_sent) begin
            @(posedge aclk);
        end
    endtask

    task automatic drop_queue(input int idx);
        logic [31:0] tkt;
        tkt = live_tickets[idx];
        live_tickets.delete(idx);
        if (stale_tickets.size() < 256) begin
            stale_tickets.push_back(tkt);
        end
        send_req(CMD_DELETE, tkt, $urandom);
    endtask

    initial begin
        logic [31:0] t_a;
        logic [31:0] t_b;
        logic [31:0] tkt;
        cmd_t        op;
        int          pick;
        int          episode;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part ----
        // slot field below the offset, then far above the range, all ones
        send_req(CMD_DEQUEUE, 32'h0000_0000, 32'h0000_0000);
        send_req(CMD_DELETE, 32'hffff_ffff, 32'hffff_ffff);
        // well-formed ticket for a slot nobody created
        send_req(CMD_ENQUEUE, {SLOT_OFFSET, NONCE_OFFSET + 16'd1}, 32'h0000_0001);
        // create ignores ticket and value
        send_req(CMD_CREATE, 32'hffff_ffff, 32'h8000_0000);
        send_req(CMD_CREATE, 32'h0000_0000, 32'h7fff_ffff);
        wait_drain();
        t_a = live_tickets[0];
        t_b = live_tickets[1];
        // empty queue, then the value extremes through one queue
        send_req(CMD_DEQUEUE, t_a, 32'hffff_ffff);
        send_req(CMD_ENQUEUE, t_a, 32'h7fff_ffff);
        send_req(CMD_ENQUEUE, t_a, 32'h8000_0000);
        send_req(CMD_ENQUEUE, t_a, 32'hffff_ffff);
        send_req(CMD_ENQUEUE, t_a, 32'h0000_0000);
        repeat (5) send_req(CMD_DEQUEUE, t_a, $urandom);
        // ticket with the wrong nonce, with the top bit set, and for a free slot
        send_req(CMD_ENQUEUE, t_b ^ 32'h0000_0001, $urandom);
        send_req(CMD_ENQUEUE, t_b | 32'h8000_0000, $urandom);
        send_req(CMD_ENQUEUE, t_b + 32'h0001_0000, $urandom);
        // delete, a stale ticket, and a create that reuses the freed slot
        drop_queue(0);
        send_req(CMD_DEQUEUE, t_a, $urandom);
        send_req(CMD_CREATE, $urandom, $urandom);

        // ---- deep sequences with random content ----
        // fill every slot while the result side holds off, run into no free slot
        hold_trigger = 1'b1;
        repeat (NQ + 2) send_req(CMD_CREATE, $urandom, $urandom);
        wait_drain();
        // one queue to full, part drain, refill across the wrap, drain to empty
        tkt = live_tickets[$urandom_range(live_tickets.size() - 1)];
        repeat (DEPTH + 2) send_req(CMD_ENQUEUE, tkt, $urandom);
        repeat (DEPTH / 2) send_req(CMD_DEQUEUE, tkt, $urandom);
        repeat (DEPTH / 4) send_req(CMD_ENQUEUE, tkt, $urandom);
        repeat (DEPTH / 2 + DEPTH / 4 + 2) send_req(CMD_DEQUEUE, tkt, $urandom);
        repeat (NQ / 2) drop_queue($urandom_range(live_tickets.size() - 1));

        // ---- random episodes ----
        episode = 0;
        while (n_sent < ITEM_TARGET) begin
            calm = (episode >= 20 && episode < 45);
            pick = $urandom_range(99);
            if (pick < 15 || (pick < 78 && live_tickets.size() == 0)) begin
                repeat ($urandom_range(1, 4)) send_req(CMD_CREATE, $urandom, $urandom);
            end else if (pick < 70) begin
                tkt = live_tickets[$urandom_range(live_tickets.size() - 1)];
                op  = (pick < 45) ? CMD_ENQUEUE : CMD_DEQUEUE;
                repeat ($urandom_range(1, 16)) send_req(op, tkt, $urandom);
            end else if (pick < 78) begin
                drop_queue($urandom_range(live_tickets.size() - 1));
            end else if (pick < 88) begin
                // noise: every field random
                send_req(cmd_t'($urandom_range(3)), $urandom, $urandom);
            end else begin
                // broken tickets: stale, bad nonce, random nonce on a real slot,
                // slot field disturbed
                tkt = (live_tickets.size() > 0)
                    ? live_tickets[$urandom_range(live_tickets.size() - 1)] : $urandom;
                case ($urandom_range(3))
                    0: begin
                        if (stale_tickets.size() > 0) begin
                            tkt = stale_tickets[$urandom_range(stale_tickets.size() - 1)];
                        end
                    end
                    1: tkt = tkt ^ (32'h1 << $urandom_range(15));
                    2: tkt = {SLOT_OFFSET + 16'($urandom_range(NQ - 1)), 16'($urandom)};
                    default: tkt = tkt ^ (32'h1 << $urandom_range(31, 16));
                endcase
                op = cmd_t'($urandom_range(1, 3));
                send_req(op, tkt, $urandom);
            end
            episode++;
        end
        calm = 1'b0;

        // ---- wrap up ----
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && awaited == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/mqtm_pkg.sv
hdl/mqtm_ram.sv
hdl/mqtm_seq.sv
hdl/multi_queue_ticket_manager.sv
tb/mqtm_result_check.sv
tb/tb_multi_queue_ticket_manager.sv
